// ===== rtl/lrmp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the logical replication message parser.
// Holds the item types, parser state types and the message layout table; no dependencies.
package lrmp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  msg_kind;
        logic [4:0]  field_code;
        logic [63:0] field_value;
        logic [15:0] column_index;
        logic        message_done;
        logic [1:0]  error_code;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_END     = 4'd0,
        OP_INT     = 4'd1,
        OP_CNT     = 4'd2,
        OP_LEN     = 4'd3,
        OP_STR     = 4'd4,
        OP_DATA    = 4'd5,
        OP_MARKN   = 4'd6,
        OP_MARKKO  = 4'd7,
        OP_MARKNOP = 4'd8,
        OP_TCOLS   = 4'd9,
        OP_RELCOLS = 4'd10,
        OP_RELIDS  = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNKNOWN = 2'd1,
        ERR_STRING  = 2'd2,
        ERR_OVERRUN = 2'd3
    } err_t;

    localparam logic [3:0] KIND_B = 4'd0;
    localparam logic [3:0] KIND_C = 4'd1;
    localparam logic [3:0] KIND_R = 4'd2;
    localparam logic [3:0] KIND_I = 4'd3;
    localparam logic [3:0] KIND_U = 4'd4;
    localparam logic [3:0] KIND_D = 4'd5;
    localparam logic [3:0] KIND_T = 4'd6;
    localparam logic [3:0] KIND_O = 4'd7;
    localparam logic [3:0] KIND_M = 4'd8;
    localparam logic [3:0] KIND_Y = 4'd9;
    localparam logic [3:0] KIND_S = 4'd10;
    localparam logic [3:0] KIND_E = 4'd11;
    localparam logic [3:0] KIND_LC = 4'd12;
    localparam logic [3:0] KIND_A = 4'd13;

    localparam logic [7:0] CH_LN = 8'h6E; // 'n'
    localparam logic [7:0] CH_LU = 8'h75; // 'u'
    localparam logic [7:0] CH_K  = 8'h4B;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_N  = 8'h4E;

    localparam int MAX_STEPS = 8;

    typedef struct packed {
        op_t        op;
        logic [3:0] size;
        logic [4:0] field;
        logic [2:0] minver;
        logic [1:0] skip;
    } step_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  kind;
        logic [2:0]  bif;
        logic [63:0] acc;
        logic [31:0] gcount;
        logic [31:0] gidx;
        logic [31:0] dleft;
        logic [1:0]  tpart;
    } ps_t;

    typedef struct packed {
        ps_t         s;
        logic        retry;
        logic        emit;
        logic [4:0]  field;
        logic [63:0] value;
        logic [15:0] col;
    } rs_t;

    function automatic step_t mk(op_t op, logic [3:0] size, logic [4:0] field,
                                 logic [2:0] minver, logic [1:0] skip);
        step_t r;
        r.op = op;
        r.size = size;
        r.field = field;
        r.minver = minver;
        r.skip = skip;
        return r;
    endfunction

    function automatic step_t step_at(logic [3:0] kind, logic [2:0] idx);
        step_t r;
        r = mk(OP_END, 4'd0, 5'd0, 3'd0, 2'd0);
        unique case (kind)
            KIND_B:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd8, 5'd1, 3'd0, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd8, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_INT, 4'd4, 5'd3, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_C:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd1, 5'd1, 3'd0, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd8, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_INT, 4'd8, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_INT, 4'd8, 5'd4, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_R:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd2, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd4, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_STR, 4'd0, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_STR, 4'd0, 5'd4, 3'd0, 2'd0);
                    3'd4: r = mk(OP_INT, 4'd1, 5'd5, 3'd0, 2'd0);
                    3'd5: r = mk(OP_CNT, 4'd2, 5'd6, 3'd0, 2'd0);
                    3'd6: r = mk(OP_RELCOLS, 4'd0, 5'd7, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_I:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd2, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd4, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_MARKN, 4'd0, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_CNT, 4'd2, 5'd4, 3'd0, 2'd0);
                    3'd4: r = mk(OP_TCOLS, 4'd0, 5'd5, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_U:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd2, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd4, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_MARKKO, 4'd0, 5'd3, 3'd0, 2'd2);
                    3'd3: r = mk(OP_CNT, 4'd2, 5'd4, 3'd0, 2'd0);
                    3'd4: r = mk(OP_TCOLS, 4'd0, 5'd5, 3'd0, 2'd0);
                    3'd5: r = mk(OP_MARKNOP, 4'd0, 5'd8, 3'd0, 2'd0);
                    3'd6: r = mk(OP_CNT, 4'd2, 5'd9, 3'd0, 2'd0);
                    3'd7: r = mk(OP_TCOLS, 4'd0, 5'd10, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_D:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd2, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd4, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_MARKKO, 4'd0, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_CNT, 4'd2, 5'd4, 3'd0, 2'd0);
                    3'd4: r = mk(OP_TCOLS, 4'd0, 5'd5, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_T:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd2, 2'd0);
                    3'd1: r = mk(OP_CNT, 4'd4, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_INT, 4'd1, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_RELIDS, 4'd4, 5'd4, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_O:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd8, 5'd1, 3'd0, 2'd0);
                    3'd1: r = mk(OP_STR, 4'd0, 5'd2, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_M:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd2, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd1, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_INT, 4'd8, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_STR, 4'd0, 5'd4, 3'd0, 2'd0);
                    3'd4: r = mk(OP_LEN, 4'd4, 5'd5, 3'd0, 2'd0);
                    3'd5: r = mk(OP_DATA, 4'd0, 5'd6, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_Y:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd2, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd4, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_STR, 4'd0, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_STR, 4'd0, 5'd4, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_S:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd0, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd1, 5'd2, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_LC:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd0, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd1, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_INT, 4'd8, 5'd3, 3'd0, 2'd0);
                    3'd3: r = mk(OP_INT, 4'd8, 5'd4, 3'd0, 2'd0);
                    3'd4: r = mk(OP_INT, 4'd8, 5'd5, 3'd0, 2'd0);
                    default: ;
                endcase
            KIND_A:
                unique case (idx)
                    3'd0: r = mk(OP_INT, 4'd4, 5'd1, 3'd0, 2'd0);
                    3'd1: r = mk(OP_INT, 4'd4, 5'd2, 3'd0, 2'd0);
                    3'd2: r = mk(OP_INT, 4'd8, 5'd3, 3'd4, 2'd0);
                    3'd3: r = mk(OP_INT, 4'd8, 5'd4, 3'd4, 2'd0);
                    default: ;
                endcase
            default: ; // stream end message and unused kind codes
        endcase
        return r;
    endfunction

    // Map a type byte to its kind; bit 4 set when the byte is a known type.
    function automatic logic [4:0] kind_of(logic [7:0] b);
        logic [4:0] r;
        unique case (b)
            8'h42:   r = {1'b1, KIND_B};
            8'h43:   r = {1'b1, KIND_C};
            8'h52:   r = {1'b1, KIND_R};
            8'h49:   r = {1'b1, KIND_I};
            8'h55:   r = {1'b1, KIND_U};
            8'h44:   r = {1'b1, KIND_D};
            8'h54:   r = {1'b1, KIND_T};
            8'h4F:   r = {1'b1, KIND_O};
            8'h4D:   r = {1'b1, KIND_M};
            8'h59:   r = {1'b1, KIND_Y};
            8'h53:   r = {1'b1, KIND_S};
            8'h45:   r = {1'b1, KIND_E};
            8'h63:   r = {1'b1, KIND_LC};
            8'h41:   r = {1'b1, KIND_A};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/logical_replication_msg_parser.sv =====
`timescale 1ns / 1ps
// Top level of the logical replication message parser: byte-serial decoder.
// Depends on lrmp_pkg for item types, parser state and the message layout table.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_item) carries one buffer byte per item,
//    with buffer_end set on the last byte of a buffer.
//  - Output channel (out_valid/out_ready/out_item) carries one token per item:
//    a type byte, a finished big-endian integer, a string or data byte, or an
//    error. message_done marks the token that completes a message.
//  - cfg_write_en/cfg_write_data set protocol_version; write only while idle.
//  - The token for a byte is registered and on the output the cycle after the byte
//    is accepted. Throughput: one byte per cycle while the output is not stalled;
//    a byte that yields no token (inner integer bytes, discarded bytes) shows nothing.
//  - The whole decode of a byte is done in combinational logic
//    that may test up to three layout steps (optional markers of an update).
//  - Reset: parser awaits a type byte, protocol_version is 1, output is empty.
//  - Stall: the output register holds its token while out_ready is low; a new
//    byte is accepted in the same cycle the held token is taken.
module logical_replication_msg_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lrmp_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output lrmp_pkg::out_item_t out_item,
    input  logic                cfg_write_en,
    input  logic [2:0]          cfg_write_data
);
    import lrmp_pkg::*;

    ps_t       state_reg, state_next;
    logic      discard_reg, discard_next;
    logic [2:0] version_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      fire;

    // Move to the first present step at or after idx; phase 0 if none.
    function automatic ps_t advance(ps_t s, logic [3:0] idx, logic [2:0] ver);
        ps_t   r;
        step_t st;
        logic  done;
        r = s;
        done = 1'b0;
        r.phase = 4'd0;
        for (int i = 0; i < MAX_STEPS; i++)
        begin
            st = step_at(s.kind, 3'(i));
            if (!done && 4'(i) >= idx)
            begin
                if (st.op == OP_END)
                    done = 1'b1;
                else if (st.minver != 3'd0 && ver < st.minver)
                    ;
                else if (st.op == OP_DATA && s.dleft == 32'd0)
                    ;
                else if ((st.op == OP_TCOLS || st.op == OP_RELCOLS || st.op == OP_RELIDS)
                         && s.gcount == 32'd0)
                    ;
                else
                begin
                    done = 1'b1;
                    r.phase = 4'(i + 1);
                    r.bif = 3'd0;
                    r.acc = 64'd0;
                    r.tpart = 2'd0;
                    r.gidx = 32'd0;
                end
            end
        end
        return r;
    endfunction

    function automatic ps_t next_column(ps_t s, logic [2:0] ver);
        ps_t r;
        r = s;
        r.gidx = s.gidx + 32'd1;
        r.tpart = 2'd0;
        r.bif = 3'd0;
        r.acc = 64'd0;
        if (r.gidx == r.gcount)
            r = advance(r, r.phase, ver);
        return r;
    endfunction

    // One layout step on byte b; retry set when b must be offered again.
    function automatic rs_t run_step(ps_t s, logic [7:0] b, logic [2:0] ver);
        rs_t         r;
        step_t       st;
        logic [15:0] col;
        logic [63:0] acc_n;
        logic        full;
        r.s = s;
        r.retry = 1'b0;
        r.emit = 1'b0;
        r.field = 5'd0;
        r.value = 64'd0;
        r.col = 16'd0;
        col = s.gidx[15:0];
        acc_n = {s.acc[55:0], b};
        st = step_at(s.kind, 3'(s.phase - 4'd1));
        if (s.phase == 4'd0 || s.phase > 4'(MAX_STEPS))
            r.s.phase = 4'd0;
        else
        begin
            unique case (st.op)
                OP_INT, OP_CNT, OP_LEN:
                begin
                    r.s.acc = acc_n;
                    full = !(({1'b0, s.bif} + 4'd1) < st.size);
                    if (!full)
                        r.s.bif = s.bif + 3'd1;
                    else
                    begin
                        r.emit = 1'b1;
                        r.field = st.field;
                        r.value = acc_n;
                        if (st.op == OP_CNT)
                            r.s.gcount = acc_n[31:0];
                        if (st.op == OP_LEN)
                            r.s.dleft = acc_n[31:0];
                        r.s = advance(r.s, s.phase, ver);
                    end
                end
                OP_STR:
                begin
                    r.emit = 1'b1;
                    r.field = st.field;
                    r.value = {56'd0, b};
                    if (b == 8'd0)
                        r.s = advance(s, s.phase, ver);
                    else
                        r.s.bif = 3'd1;
                end
                OP_DATA:
                begin
                    r.emit = 1'b1;
                    r.field = st.field;
                    r.value = {56'd0, b};
                    r.s.dleft = s.dleft - 32'd1;
                    if (r.s.dleft == 32'd0)
                        r.s = advance(r.s, s.phase, ver);
                end
                OP_MARKN:
                begin
                    r.emit = 1'b1;
                    r.field = st.field;
                    r.value = (b == CH_N) ? {56'd0, b} : 64'd0;
                    r.s = advance(s, s.phase, ver);
                end
                OP_MARKKO:
                begin
                    if (b == CH_K || b == CH_O)
                    begin
                        r.emit = 1'b1;
                        r.field = st.field;
                        r.value = {56'd0, b};
                        r.s = advance(s, s.phase, ver);
                    end
                    else
                    begin
                        r.s = advance(s, s.phase + {2'd0, st.skip}, ver);
                        r.retry = 1'b1;
                    end
                end
                OP_MARKNOP:
                begin
                    if (b == CH_N)
                    begin
                        r.emit = 1'b1;
                        r.field = st.field;
                        r.value = {56'd0, b};
                    end
                    else
                        r.retry = 1'b1;
                    r.s = advance(s, s.phase, ver);
                end
                OP_TCOLS:
                begin
                    r.emit = 1'b1;
                    r.col = col;
                    if (s.tpart == 2'd0)
                    begin
                        r.field = st.field;
                        r.value = {56'd0, b};
                        if (b == CH_LN || b == CH_LU)
                            r.s = next_column(s, ver);
                        else
                        begin
                            r.s.tpart = 2'd1;
                            r.s.bif = 3'd0;
                            r.s.acc = 64'd0;
                        end
                    end
                    else if (s.tpart == 2'd1)
                    begin
                        r.s.acc = acc_n;
                        if (s.bif != 3'd3)
                        begin
                            r.emit = 1'b0;
                            r.s.bif = s.bif + 3'd1;
                        end
                        else
                        begin
                            r.field = st.field + 5'd1;
                            r.value = acc_n;
                            r.s.dleft = acc_n[31:0];
                            if (acc_n[31:0] == 32'd0)
                                r.s = next_column(r.s, ver);
                            else
                                r.s.tpart = 2'd2;
                        end
                    end
                    else
                    begin
                        r.field = st.field + 5'd2;
                        r.value = {56'd0, b};
                        r.s.dleft = s.dleft - 32'd1;
                        if (r.s.dleft == 32'd0)
                            r.s = next_column(r.s, ver);
                    end
                end
                OP_RELCOLS:
                begin
                    r.emit = 1'b1;
                    r.col = col;
                    if (s.tpart == 2'd0)
                    begin
                        r.field = st.field;
                        r.value = {56'd0, b};
                        r.s.tpart = 2'd1;
                        r.s.bif = 3'd0;
                    end
                    else if (s.tpart == 2'd1)
                    begin
                        r.field = st.field + 5'd1;
                        r.value = {56'd0, b};
                        if (b == 8'd0)
                        begin
                            r.s.tpart = 2'd2;
                            r.s.bif = 3'd0;
                            r.s.acc = 64'd0;
                        end
                        else
                            r.s.bif = 3'd1;
                    end
                    else
                    begin
                        r.s.acc = acc_n;
                        if (s.bif != 3'd3)
                        begin
                            r.emit = 1'b0;
                            r.s.bif = s.bif + 3'd1;
                        end
                        else
                        begin
                            r.field = st.field + {3'd0, s.tpart};
                            r.value = acc_n;
                            if (s.tpart == 2'd2)
                            begin
                                r.s.tpart = 2'd3;
                                r.s.bif = 3'd0;
                                r.s.acc = 64'd0;
                            end
                            else
                                r.s = next_column(r.s, ver);
                        end
                    end
                end
                OP_RELIDS:
                begin
                    r.s.acc = acc_n;
                    if (s.bif != 3'd3)
                        r.s.bif = s.bif + 3'd1;
                    else
                    begin
                        r.emit = 1'b1;
                        r.col = col;
                        r.field = st.field;
                        r.value = acc_n;
                        r.s = next_column(r.s, ver);
                    end
                end
                default: r.s.phase = 4'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic string_open(ps_t s);
        step_t st;
        st = step_at(s.kind, 3'(s.phase - 4'd1));
        if (s.phase == 4'd0 || s.phase > 4'(MAX_STEPS))
            return 1'b0;
        if (st.op == OP_STR)
            return s.bif != 3'd0;
        if (st.op == OP_RELCOLS)
            return s.tpart == 2'd1 && s.bif != 3'd0;
        return 1'b0;
    endfunction

    function automatic ps_t clear_msg(ps_t s);
        ps_t r;
        r = s;
        r.phase = 4'd0;
        r.bif = 3'd0;
        r.acc = 64'd0;
        r.gcount = 32'd0;
        r.gidx = 32'd0;
        r.dleft = 32'd0;
        r.tpart = 2'd0;
        return r;
    endfunction

    // Accept a byte whenever the result register is empty or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign fire = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

    always_comb
    begin
        logic [7:0] b;
        logic       last;
        logic [4:0] k;
        rs_t        rs;
        logic       emit;
        logic       stop;
        logic [4:0] fld;
        logic [63:0] val;
        logic [15:0] col;
        err_t       err;
        logic [3:0] err_kind;
        ps_t        s;

        b = in_item.data_byte;
        last = in_item.buffer_end;
        k = kind_of(b);
        s = state_reg;
        emit = 1'b0;
        stop = 1'b0;
        fld = 5'd0;
        val = 64'd0;
        col = 16'd0;
        err = ERR_NONE;
        err_kind = 4'd0;
        discard_next = discard_reg;
        rs = '0;

        if (discard_reg)
        begin
            // Drop bytes up to and including the end of the buffer.
            if (last)
                discard_next = 1'b0;
        end
        else if (state_reg.phase == 4'd0)
        begin
            if (!k[4])
            begin
                err = ERR_UNKNOWN;
                s = clear_msg(s);
                discard_next = !last;
            end
            else
            begin
                s.kind = k[3:0];
                emit = 1'b1;
                val = {56'd0, b};
                s = clear_msg(s);
                s = advance(s, 4'd0, version_reg);
            end
        end
        else
        begin
            // Optional markers may hand the byte on, at most three steps deep.
            for (int t = 0; t < 3; t++)
            begin
                if (!stop && s.phase != 4'd0)
                begin
                    rs = run_step(s, b, version_reg);
                    s = rs.s;
                    if (rs.emit)
                    begin
                        emit = 1'b1;
                        fld = rs.field;
                        val = rs.value;
                        col = rs.col;
                    end
                    if (!rs.retry)
                        stop = 1'b1;
                end
            end
        end

        if (!discard_reg && err == ERR_NONE && last && s.phase != 4'd0)
        begin
            err = string_open(s) ? ERR_STRING : ERR_OVERRUN;
            err_kind = s.kind;
            s = clear_msg(s);
        end

        state_next = s;
        out_item_next = out_item_reg;
        if (err != ERR_NONE)
        begin
            out_item_next.msg_kind = err_kind;
            out_item_next.field_code = 5'd0;
            out_item_next.field_value = {56'd0, b};
            out_item_next.column_index = 16'd0;
            out_item_next.message_done = 1'b0;
            out_item_next.error_code = err;
        end
        else
        begin
            out_item_next.msg_kind = s.kind;
            out_item_next.field_code = fld;
            out_item_next.field_value = val;
            out_item_next.column_index = col;
            out_item_next.message_done = s.phase == 4'd0;
            out_item_next.error_code = ERR_NONE;
        end

        if (fire)
            out_valid_next = (err != ERR_NONE) || emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            discard_reg <= 1'b0;
            version_reg <= 3'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= state_next;
                discard_reg <= discard_next;
            end
            if (cfg_write_en)
                version_reg <= cfg_write_data;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register: load only on an accepted byte, hold while stalled.
    always_ff @(posedge clk)
    begin
        if (fire)
            out_item_reg <= out_item_next;
    end

endmodule

// ===== test/lrmp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the logical replication message parser: watches both channels and the
// version register, predicts each token and compares it. Depends on lrmp_pkg.
module lrmp_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  lrmp_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_ready,
    input  lrmp_pkg::out_item_t out_item,
    input  logic                cfg_write_en,
    input  logic [2:0]          cfg_write_data,
    output int                  fails,
    output int                  pending
);
    import lrmp_pkg::*;

    typedef struct {
        op_t op;
        int  size;
        int  field;
        int  minver;
        int  skip;
    } lay_t;

    out_item_t   token_q[$];
    logic [2:0]  proto_ver = 3'd1;
    int          cur_step = 0;
    logic [3:0]  cur_kind = 4'd0;
    int          int_bytes = 0;
    logic [63:0] accum = '0;
    logic [31:0] grp_total = '0;
    logic [31:0] grp_pos = '0;
    logic [31:0] bytes_left = '0;
    int          col_part = 0;
    bit          skipping = 0;
    bit          tk_on;
    int          tk_field;
    logic [63:0] tk_value;
    logic [15:0] tk_col;

    initial fails = 0;
    assign pending = token_q.size();

    function automatic lay_t row(logic [3:0] k, int i);
        lay_t r;
        r = '{OP_END, 0, 0, 0, 0};
        case (k)
            KIND_B: case (i)
                0: r = '{OP_INT, 8, 1, 0, 0};
                1: r = '{OP_INT, 8, 2, 0, 0};
                2: r = '{OP_INT, 4, 3, 0, 0};
                default: ;
            endcase
            KIND_C: case (i)
                0: r = '{OP_INT, 1, 1, 0, 0};
                1: r = '{OP_INT, 8, 2, 0, 0};
                2: r = '{OP_INT, 8, 3, 0, 0};
                3: r = '{OP_INT, 8, 4, 0, 0};
                default: ;
            endcase
            KIND_R: case (i)
                0: r = '{OP_INT, 4, 1, 2, 0};
                1: r = '{OP_INT, 4, 2, 0, 0};
                2: r = '{OP_STR, 0, 3, 0, 0};
                3: r = '{OP_STR, 0, 4, 0, 0};
                4: r = '{OP_INT, 1, 5, 0, 0};
                5: r = '{OP_CNT, 2, 6, 0, 0};
                6: r = '{OP_RELCOLS, 0, 7, 0, 0};
                default: ;
            endcase
            KIND_I, KIND_D: case (i)
                0: r = '{OP_INT, 4, 1, 2, 0};
                1: r = '{OP_INT, 4, 2, 0, 0};
                2: r = (k == KIND_I) ? '{OP_MARKN, 0, 3, 0, 0} : '{OP_MARKKO, 0, 3, 0, 0};
                3: r = '{OP_CNT, 2, 4, 0, 0};
                4: r = '{OP_TCOLS, 0, 5, 0, 0};
                default: ;
            endcase
            KIND_U: case (i)
                0: r = '{OP_INT, 4, 1, 2, 0};
                1: r = '{OP_INT, 4, 2, 0, 0};
                2: r = '{OP_MARKKO, 0, 3, 0, 2};
                3: r = '{OP_CNT, 2, 4, 0, 0};
                4: r = '{OP_TCOLS, 0, 5, 0, 0};
                5: r = '{OP_MARKNOP, 0, 8, 0, 0};
                6: r = '{OP_CNT, 2, 9, 0, 0};
                7: r = '{OP_TCOLS, 0, 10, 0, 0};
                default: ;
            endcase
            KIND_T: case (i)
                0: r = '{OP_INT, 4, 1, 2, 0};
                1: r = '{OP_CNT, 4, 2, 0, 0};
                2: r = '{OP_INT, 1, 3, 0, 0};
                3: r = '{OP_RELIDS, 4, 4, 0, 0};
                default: ;
            endcase
            KIND_O: case (i)
                0: r = '{OP_INT, 8, 1, 0, 0};
                1: r = '{OP_STR, 0, 2, 0, 0};
                default: ;
            endcase
            KIND_M: case (i)
                0: r = '{OP_INT, 4, 1, 2, 0};
                1: r = '{OP_INT, 1, 2, 0, 0};
                2: r = '{OP_INT, 8, 3, 0, 0};
                3: r = '{OP_STR, 0, 4, 0, 0};
                4: r = '{OP_LEN, 4, 5, 0, 0};
                5: r = '{OP_DATA, 0, 6, 0, 0};
                default: ;
            endcase
            KIND_Y: case (i)
                0: r = '{OP_INT, 4, 1, 2, 0};
                1: r = '{OP_INT, 4, 2, 0, 0};
                2: r = '{OP_STR, 0, 3, 0, 0};
                3: r = '{OP_STR, 0, 4, 0, 0};
                default: ;
            endcase
            KIND_S: case (i)
                0: r = '{OP_INT, 4, 1, 0, 0};
                1: r = '{OP_INT, 1, 2, 0, 0};
                default: ;
            endcase
            KIND_LC: case (i)
                0: r = '{OP_INT, 4, 1, 0, 0};
                1: r = '{OP_INT, 1, 2, 0, 0};
                2: r = '{OP_INT, 8, 3, 0, 0};
                3: r = '{OP_INT, 8, 4, 0, 0};
                4: r = '{OP_INT, 8, 5, 0, 0};
                default: ;
            endcase
            KIND_A: case (i)
                0: r = '{OP_INT, 4, 1, 0, 0};
                1: r = '{OP_INT, 4, 2, 0, 0};
                2: r = '{OP_INT, 8, 3, 4, 0};
                3: r = '{OP_INT, 8, 4, 4, 0};
                default: ;
            endcase
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] type_to_kind(logic [7:0] b);
        case (b)
            8'h42: return {1'b1, KIND_B};
            8'h43: return {1'b1, KIND_C};
            8'h52: return {1'b1, KIND_R};
            8'h49: return {1'b1, KIND_I};
            8'h55: return {1'b1, KIND_U};
            8'h44: return {1'b1, KIND_D};
            8'h54: return {1'b1, KIND_T};
            8'h4F: return {1'b1, KIND_O};
            8'h4D: return {1'b1, KIND_M};
            8'h59: return {1'b1, KIND_Y};
            8'h53: return {1'b1, KIND_S};
            8'h45: return {1'b1, KIND_E};
            8'h63: return {1'b1, KIND_LC};
            8'h41: return {1'b1, KIND_A};
            default: return 5'd0;
        endcase
    endfunction

    function automatic void give(int f, logic [63:0] v, logic [15:0] c);
        tk_on = 1;
        tk_field = f;
        tk_value = v;
        tk_col = c;
    endfunction

    function automatic void reset_msg();
        cur_step = 0;
        int_bytes = 0;
        accum = '0;
        grp_total = '0;
        grp_pos = '0;
        bytes_left = '0;
        col_part = 0;
    endfunction

    // Land on the first step at or after idx that is present; 0 when the message is over.
    function automatic void goto_step(int idx);
        lay_t l;
        for (int j = idx; j < MAX_STEPS; j++)
        begin
            l = row(cur_kind, j);
            if (l.op == OP_END)
                break;
            if (l.minver != 0 && proto_ver < l.minver)
                continue;
            if (l.op == OP_DATA && bytes_left == 0)
                continue;
            if ((l.op == OP_TCOLS || l.op == OP_RELCOLS || l.op == OP_RELIDS)
                && grp_total == 0)
                continue;
            cur_step = j + 1;
            int_bytes = 0;
            accum = '0;
            col_part = 0;
            grp_pos = '0;
            return;
        end
        cur_step = 0;
    endfunction

    function automatic bit shift_in(logic [7:0] b, int size);
        accum = {accum[55:0], b};
        if (int_bytes + 1 < size)
        begin
            int_bytes++;
            return 0;
        end
        return 1;
    endfunction

    function automatic void col_next();
        grp_pos++;
        col_part = 0;
        int_bytes = 0;
        accum = '0;
        if (grp_pos == grp_total)
            goto_step(cur_step);
    endfunction

    // Returns 1 when the byte must be offered to the following step.
    function automatic bit walk_step(logic [7:0] b);
        lay_t        l;
        logic [15:0] c;
        c = grp_pos[15:0];
        if (cur_step == 0 || cur_step > MAX_STEPS)
        begin
            cur_step = 0;
            return 0;
        end
        l = row(cur_kind, cur_step - 1);
        case (l.op)
            OP_INT, OP_CNT, OP_LEN:
            begin
                if (!shift_in(b, l.size))
                    return 0;
                give(l.field, accum, 0);
                if (l.op == OP_CNT)
                    grp_total = accum[31:0];
                if (l.op == OP_LEN)
                    bytes_left = accum[31:0];
                goto_step(cur_step);
            end
            OP_STR:
            begin
                give(l.field, b, 0);
                if (b == 0)
                    goto_step(cur_step);
                else
                    int_bytes = 1;
            end
            OP_DATA:
            begin
                give(l.field, b, 0);
                bytes_left--;
                if (bytes_left == 0)
                    goto_step(cur_step);
            end
            OP_MARKN:
            begin
                give(l.field, (b == CH_N) ? b : 0, 0);
                goto_step(cur_step);
            end
            OP_MARKKO:
            begin
                if (b == CH_K || b == CH_O)
                begin
                    give(l.field, b, 0);
                    goto_step(cur_step);
                    return 0;
                end
                goto_step(cur_step + l.skip);
                return 1;
            end
            OP_MARKNOP:
            begin
                goto_step(cur_step);
                if (b != CH_N)
                    return 1;
                give(l.field, b, 0);
            end
            OP_TCOLS:
            begin
                if (col_part == 0)
                begin
                    give(l.field, b, c);
                    if (b == CH_LN || b == CH_LU)
                        col_next();
                    else
                    begin
                        col_part = 1;
                        int_bytes = 0;
                        accum = '0;
                    end
                end
                else if (col_part == 1)
                begin
                    if (!shift_in(b, 4))
                        return 0;
                    give(l.field + 1, accum, c);
                    bytes_left = accum[31:0];
                    if (bytes_left == 0)
                        col_next();
                    else
                        col_part = 2;
                end
                else
                begin
                    give(l.field + 2, b, c);
                    bytes_left--;
                    if (bytes_left == 0)
                        col_next();
                end
            end
            OP_RELCOLS:
            begin
                if (col_part == 0)
                begin
                    give(l.field, b, c);
                    col_part = 1;
                    int_bytes = 0;
                end
                else if (col_part == 1)
                begin
                    give(l.field + 1, b, c);
                    if (b == 0)
                    begin
                        col_part = 2;
                        int_bytes = 0;
                        accum = '0;
                    end
                    else
                        int_bytes = 1;
                end
                else
                begin
                    if (!shift_in(b, 4))
                        return 0;
                    give(l.field + col_part, accum, c);
                    if (col_part == 2)
                    begin
                        col_part = 3;
                        int_bytes = 0;
                        accum = '0;
                    end
                    else
                        col_next();
                end
            end
            OP_RELIDS:
            begin
                if (!shift_in(b, 4))
                    return 0;
                give(l.field, accum, c);
                col_next();
            end
            default: cur_step = 0;
        endcase
        return 0;
    endfunction

    function automatic bit string_open();
        lay_t l;
        if (cur_step == 0 || cur_step > MAX_STEPS)
            return 0;
        l = row(cur_kind, cur_step - 1);
        if (l.op == OP_STR)
            return int_bytes != 0;
        if (l.op == OP_RELCOLS)
            return col_part == 1 && int_bytes != 0;
        return 0;
    endfunction

    // Decode one byte; push the token it yields, if any.
    function automatic void decode_byte(logic [7:0] b, logic last);
        err_t       err;
        logic [3:0] ekind;
        logic [4:0] tk;
        out_item_t  o;
        err = ERR_NONE;
        ekind = 4'd0;
        if (skipping)
        begin
            if (last)
                skipping = 0;
            return;
        end
        tk_on = 0;
        if (cur_step == 0)
        begin
            tk = type_to_kind(b);
            if (!tk[4])
            begin
                err = ERR_UNKNOWN;
                reset_msg();
                skipping = !last;
            end
            else
            begin
                cur_kind = tk[3:0];
                give(0, b, 0);
                reset_msg();
                goto_step(0);
            end
        end
        else
        begin
            for (int t = 0; t < 3 && cur_step != 0; t++)
                if (!walk_step(b))
                    break;
        end
        if (err == ERR_NONE && last && cur_step != 0)
        begin
            err = string_open() ? ERR_STRING : ERR_OVERRUN;
            ekind = cur_kind;
            reset_msg();
        end
        if (err != ERR_NONE)
        begin
            o.msg_kind = ekind;
            o.field_code = 0;
            o.field_value = b;
            o.column_index = 0;
            o.message_done = 0;
            o.error_code = err;
            token_q.push_back(o);
        end
        else if (tk_on)
        begin
            o.msg_kind = cur_kind;
            o.field_code = tk_field[4:0];
            o.field_value = tk_value;
            o.column_index = tk_col;
            o.message_done = (cur_step == 0);
            o.error_code = ERR_NONE;
            token_q.push_back(o);
        end
    endfunction

    function automatic void field_check(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            $error("field %s: expected %h, got %h", name, e, a);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n)
        begin
            // Compare first: a token on the output belongs to an earlier byte.
            if (out_valid && out_ready)
            begin
                if (token_q.size() == 0)
                begin
                    $error("token with nothing expected: %p", out_item);
                    fails++;
                end
                else
                begin
                    e = token_q.pop_front();
                    field_check("msg_kind", e.msg_kind, out_item.msg_kind);
                    field_check("field_code", e.field_code, out_item.field_code);
                    field_check("field_value", e.field_value, out_item.field_value);
                    field_check("column_index", e.column_index, out_item.column_index);
                    field_check("message_done", e.message_done, out_item.message_done);
                    field_check("error_code", e.error_code, out_item.error_code);
                end
            end
            if (in_valid && in_ready)
                decode_byte(in_item.data_byte, in_item.buffer_end);
            if (cfg_write_en)
                proto_ver = cfg_write_data;
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the logical replication message parser: builds byte buffers of
// pgoutput messages and gives the verdict. Depends on lrmp_pkg, lrmp_checker and the parser.
module tb;
    import lrmp_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 0;
    out_item_t out_item;
    logic      cfg_write_en = 0;
    logic [2:0] cfg_write_data = 3'd1;
    int        fails;
    int        pending;

    // Stimulus controls and state; calm and hold_req are shared with the receiver process.
    bit         calm = 0;
    bit         hold_req = 0;
    logic [2:0] ver = 3'd1;
    logic [7:0] buf_q[$];
    int         bytes_sent = 0;
    int         settings_done = 0;

    logical_replication_msg_parser DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
    );

    lrmp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .fails(fails), .pending(pending)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Hard stop in case the parser hangs.
    initial
    begin
        #3ms;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random back-pressure, a quiet stretch, and one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else if (calm)
                out_ready <= 1;
            else
                out_ready <= ($urandom_range(0, 99) >= 21);
        end
    end

    function automatic logic [7:0] kind_letter(logic [3:0] k);
        case (k)
            KIND_B:  return 8'h42;
            KIND_C:  return 8'h43;
            KIND_R:  return 8'h52;
            KIND_I:  return 8'h49;
            KIND_U:  return 8'h55;
            KIND_D:  return 8'h44;
            KIND_T:  return 8'h54;
            KIND_O:  return 8'h4F;
            KIND_M:  return 8'h4D;
            KIND_Y:  return 8'h59;
            KIND_S:  return 8'h53;
            KIND_E:  return 8'h45;
            KIND_LC: return 8'h63;
            default: return 8'h41;
        endcase
    endfunction

    // Random integer with extra weight on all zeros and all ones.
    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_int(int n, logic [63:0] v);
        for (int i = n - 1; i >= 0; i--)
            buf_q.push_back(v[8*i +: 8]);
    endtask

    task automatic add_str();
        int n;
        n = $urandom_range(0, 4);
        repeat (n)
            buf_q.push_back(8'($urandom_range(1, 255)));
        buf_q.push_back(8'h00);
    endtask

    // Column count, then per column a kind byte and, unless null or unchanged, data.
    task automatic add_tuple();
        int n;
        int kd;
        int len;
        n = $urandom_range(0, 3);
        add_int(2, n);
        repeat (n)
        begin
            kd = $urandom_range(0, 3);
            if (kd == 0)
                buf_q.push_back(CH_LN);
            else if (kd == 1)
                buf_q.push_back(CH_LU);
            else
            begin
                buf_q.push_back(kd == 2 ? 8'h74 : 8'h62);
                len = $urandom_range(0, 3);
                add_int(4, len);
                repeat (len)
                    buf_q.push_back(8'($urandom));
            end
        end
    endtask

    task automatic add_msg(logic [3:0] k);
        int n;
        bit xid;
        xid = (ver >= 2);
        buf_q.push_back(kind_letter(k));
        case (k)
            KIND_B:
            begin
                add_int(8, pick64());
                add_int(8, pick64());
                add_int(4, pick64());
            end
            KIND_C, KIND_LC:
            begin
                if (k == KIND_LC)
                    add_int(4, pick64());
                add_int(1, pick64());
                add_int(8, pick64());
                add_int(8, pick64());
                add_int(8, pick64());
            end
            KIND_R:
            begin
                if (xid)
                    add_int(4, pick64());
                add_int(4, pick64());
                add_str();
                add_str();
                add_int(1, pick64());
                n = $urandom_range(0, 3);
                add_int(2, n);
                repeat (n)
                begin
                    add_int(1, pick64());
                    add_str();
                    add_int(4, pick64());
                    add_int(4, pick64());
                end
            end
            KIND_I, KIND_U, KIND_D:
            begin
                if (xid)
                    add_int(4, pick64());
                add_int(4, pick64());
                n = $urandom_range(0, 9);
                if (k == KIND_I)
                begin
                    buf_q.push_back(n < 8 ? CH_N : 8'($urandom));
                    add_tuple();
                end
                else if (k == KIND_D)
                begin
                    // Mostly a key or old marker; sometimes none at all.
                    if (n < 8)
                        buf_q.push_back(n < 4 ? CH_K : CH_O);
                    add_tuple();
                end
                else
                begin
                    if (n < 6)
                    begin
                        buf_q.push_back(n < 3 ? CH_K : CH_O);
                        add_tuple();
                    end
                    if ($urandom_range(0, 4) != 0)
                        buf_q.push_back(CH_N);
                    add_tuple();
                end
            end
            KIND_T:
            begin
                if (xid)
                    add_int(4, pick64());
                n = $urandom_range(0, 3);
                add_int(4, n);
                add_int(1, pick64());
                repeat (n)
                    add_int(4, pick64());
            end
            KIND_O:
            begin
                add_int(8, pick64());
                add_str();
            end
            KIND_M:
            begin
                if (xid)
                    add_int(4, pick64());
                add_int(1, pick64());
                add_int(8, pick64());
                add_str();
                n = $urandom_range(0, 4);
                add_int(4, n);
                repeat (n)
                    buf_q.push_back(8'($urandom));
            end
            KIND_Y:
            begin
                if (xid)
                    add_int(4, pick64());
                add_int(4, pick64());
                add_str();
                add_str();
            end
            KIND_S:
            begin
                add_int(4, pick64());
                add_int(1, pick64());
            end
            KIND_A:
            begin
                add_int(4, pick64());
                add_int(4, pick64());
                if (ver >= 4)
                begin
                    add_int(8, pick64());
                    add_int(8, pick64());
                end
            end
            default: ;
        endcase
    endtask

    // Offer one item; hold valid and payload until taken.
    task automatic send(logic [7:0] b, logic last);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_item <= '{data_byte: b, buffer_end: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Drain the assembled buffer, marking its last byte.
    task automatic flush_buf();
        for (int i = 0; i < buf_q.size(); i++)
            send(buf_q[i], i == buf_q.size() - 1);
        buf_q.delete();
    endtask

    // Well-formed buffers mostly; some cut short, some with trailing junk, some pure noise.
    task automatic random_buffer();
        int r;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 6))
                buf_q.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                add_msg(4'($urandom_range(0, 13)));
            if (r < 20 && buf_q.size() > 1)
            begin
                cut = $urandom_range(1, buf_q.size() - 1);
                repeat (cut)
                    void'(buf_q.pop_back());
            end
            else if (r < 26)
                buf_q.push_back(8'($urandom));
        end
        flush_buf();
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    task automatic set_version(logic [2:0] v);
        cfg_write_en <= 1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 0;
        ver = v;
        settings_done++;
    endtask

    initial
    begin
        logic [2:0] vers[8];
        int goal;
        bit hold_done;
        vers = '{3'd4, 3'd2, 3'd3, 3'd1, 3'd0, 3'd7, 3'd4, 3'd5};
        hold_done = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: stream end, unknown type with the rest of its buffer dropped,
        // all-zero and all-ones integers, an unterminated string, an overrun,
        // and an update that carries no old tuple.
        add_msg(KIND_E);
        flush_buf();
        buf_q = '{8'hFF, 8'h42, 8'h00};
        flush_buf();
        buf_q = '{8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'h53, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        flush_buf();
        buf_q = '{8'h4F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h61};
        flush_buf();
        buf_q = '{8'h42, 8'h11};
        flush_buf();
        buf_q = '{8'h55, 8'h00, 8'h00, 8'h00, 8'h07, 8'h4E, 8'h00, 8'h00};
        flush_buf();
        wait_idle();

        // Random phases, one per version setting; the extremes and out-of-range
        // values are among them.
        goal = 240;
        for (int p = 0; p < 8; p++)
        begin
            set_version(vers[p]);
            calm = (p == 2);
            while (bytes_sent < goal)
            begin
                random_buffer();
                // Long receiver hold-off while the sender keeps offering.
                if (p == 4 && !hold_done && bytes_sent > goal - 200)
                begin
                    hold_req = 1;
                    hold_done = 1;
                end
            end
            calm = 0;
            goal += 240;
            // Pause the sender until every token is back, then change version.
            wait_idle();
        end

        repeat (5)
            @(posedge clk);
        $display("Run covered %0d bytes of pgoutput buffers over %0d version settings,",
                 bytes_sent, settings_done);
        $display("with truncated buffers, unknown types and long output stalls.");
        if (fails == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
